### rtl/core/s2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2d_pkg: shared types and constants
// Character codes, digit buffer layout and the queue entry that passes
// between the digit extraction front and the character emission back.
// ----------------------------------------------------------------------------
package s2d_pkg;

    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int MAX_DIGITS  = 10;
    localparam int DIG_W       = 4;
    localparam int NDIG_W      = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
    localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    typedef logic [MAX_DIGITS-1:0][DIG_W-1:0] s2d_digits_t;

    typedef struct packed {
        logic              neg;
        logic [NDIG_W-1:0] ndig;
        s2d_digits_t       digits;
    } s2d_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } s2d_qstat_t;

endpackage

### rtl/core/s2d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2d_front: sign split and digit extraction
// Takes one number, splits off the sign, then peels one decimal digit per
// cycle (least significant first) through a reciprocal multiply by 1/10.
// ----------------------------------------------------------------------------
module s2d_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  num_valid,
    output logic                                  num_stall,
    input  logic signed [s2d_pkg::VALUE_W-1:0]    value,
    input  s2d_pkg::s2d_qstat_t                   qstat,
    output logic                                  push,
    output s2d_pkg::s2d_entry_t                   push_data
);
    import s2d_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } fstate_t;

    fstate_t              state_reg;
    fstate_t              state_next;
    logic                 neg_reg;
    logic                 neg_next;
    logic [VALUE_W-1:0]   mag_reg;
    logic [VALUE_W-1:0]   mag_next;
    logic [NDIG_W-1:0]    nd_reg;
    logic [NDIG_W-1:0]    nd_next;
    s2d_digits_t          dig_reg;
    s2d_digits_t          dig_next;

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   rem_full;
    logic                 accept;
    logic                 conv_done;

    assign prod      = 64'(mag_reg) * 64'(RECIP_10);
    assign quot      = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
    assign rem_full  = mag_reg - ((quot << 3) + (quot << 1));
    assign conv_done = (quot == '0) || (nd_reg == NDIG_W'(MAX_DIGITS - 1));

    assign push      = (state_reg == F_PUSH) && !qstat.full;
    assign num_stall = !((state_reg == F_IDLE) || push);
    assign accept    = num_valid && !num_stall;

    assign push_data.neg    = neg_reg;
    assign push_data.ndig   = nd_reg;
    assign push_data.digits = dig_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_CONV;
                end
            end
            F_CONV:
            begin
                if (conv_done)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push)
                begin
                    state_next = accept ? F_CONV : F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        neg_next = neg_reg;
        mag_next = mag_reg;
        nd_next  = nd_reg;
        dig_next = dig_reg;
        if (accept)
        begin
            neg_next = value[VALUE_W-1];
            mag_next = value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);
            nd_next  = '0;
        end
        else if (state_reg == F_CONV)
        begin
            dig_next[nd_reg] = rem_full[DIG_W-1:0];
            mag_next         = quot;
            nd_next          = nd_reg + NDIG_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        nd_reg  <= nd_next;
        dig_reg <= dig_next;
    end

endmodule

### rtl/core/s2d_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2d_queue: digit string queue
// Short first-in first-out queue of converted numbers between the front
// and the back; the head entry is read in place.
// ----------------------------------------------------------------------------
module s2d_queue
#(
    parameter int DEPTH = s2d_pkg::QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  s2d_pkg::s2d_entry_t  push_data,
    input  logic                 pop,
    output s2d_pkg::s2d_entry_t  pop_data,
    output s2d_pkg::s2d_qstat_t  qstat
);
    import s2d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    s2d_entry_t         mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign pop_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/s2d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2d_back: character emission
// Walks the queue head, emitting the sign and then the digits most
// significant first into an output register, one character per cycle unless char_stall holds it.
// ----------------------------------------------------------------------------
module s2d_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  s2d_pkg::s2d_entry_t             head,
    input  s2d_pkg::s2d_qstat_t             qstat,
    output logic                            pop,
    output logic                            char_valid,
    input  logic                            char_stall,
    output logic [s2d_pkg::CHAR_W-1:0]      char_code,
    output logic                            last_char
);
    import s2d_pkg::*;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CHAR_W-1:0]    char_reg;
    logic [CHAR_W-1:0]    char_next;
    logic                 last_reg;
    logic                 last_next;
    logic                 sign_sent_reg;
    logic                 sign_sent_next;
    logic [NDIG_W-1:0]    pos_reg;
    logic [NDIG_W-1:0]    pos_next;

    logic                 adv;
    logic                 emit;
    logic                 sign_phase;
    logic [NDIG_W-1:0]    dig_idx;
    logic                 final_dig;

    assign adv        = !out_valid_reg || !char_stall;
    assign emit       = adv && !qstat.empty;
    assign sign_phase = head.neg && !sign_sent_reg;
    assign dig_idx    = head.ndig - NDIG_W'(1) - pos_reg;
    assign final_dig  = (dig_idx == '0);
    assign pop        = emit && !sign_phase && final_dig;

    assign char_valid = out_valid_reg;
    assign char_code  = char_reg;
    assign last_char  = last_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        sign_sent_next = sign_sent_reg;
        pos_next       = pos_reg;
        if (adv)
        begin
            out_valid_next = emit;
        end
        if (emit)
        begin
            if (sign_phase)
            begin
                char_next      = CHAR_MINUS;
                last_next      = 1'b0;
                sign_sent_next = 1'b1;
            end
            else
            begin
                char_next = CHAR_ZERO + CHAR_W'(head.digits[dig_idx]);
                last_next = final_dig;
                if (final_dig)
                begin
                    sign_sent_next = 1'b0;
                    pos_next       = '0;
                end
                else
                begin
                    pos_next = pos_reg + NDIG_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sign_sent_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sign_sent_reg <= sign_sent_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

### rtl/core/signed_int_to_decimal_chars.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_chars: signed 32-bit integer to decimal ASCII
// Converts each number to its decimal text, sign first, most significant
// digit next, flagging the final character.
//
//  channel  direction  handshake              payload
//  number   in         num_valid / num_stall  value[31:0] signed
//  char     out        char_valid/char_stall  char_code[7:0], last_char
//
// The front extracts the digits in its divide-by-ten multiplier loop and
// then hands the number off to the queue. The back sends one character
// per cycle unless char_stall holds it: a minus sign for a negative number,
// then the digits. The front takes in the next number while the back emits.
// rst_n clears all control state asynchronously; no clearing pass follows.
// A stall on the char side fills the output register, then the queue,
// then holds the front; the number side is stalled only while it is busy.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_chars
#(
    parameter int QUEUE_DEPTH = s2d_pkg::QUEUE_DEPTH
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                num_valid,
    output logic                                num_stall,
    input  logic signed [s2d_pkg::VALUE_W-1:0]  value,
    output logic                                char_valid,
    input  logic                                char_stall,
    output logic [s2d_pkg::CHAR_W-1:0]          char_code,
    output logic                                last_char
);
    import s2d_pkg::*;

    s2d_entry_t push_data;
    s2d_entry_t head;
    s2d_qstat_t qstat;
    logic       push;
    logic       pop;

    s2d_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num_valid),
        .num_stall (num_stall),
        .value     (value),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    s2d_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (head),
        .qstat     (qstat)
    );

    s2d_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .qstat      (qstat),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_code  (char_code),
        .last_char  (last_char)
    );

endmodule

### rtl/core/s2d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2d_checker: port-level checks
// Watches the character channel of the converter for handshake and
// character sequence errors.
// ----------------------------------------------------------------------------
module s2d_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           char_valid,
    input logic                           char_stall,
    input logic [s2d_pkg::CHAR_W-1:0]     char_code,
    input logic                           last_char
);
    import s2d_pkg::*;

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> char_valid)
        else $error("char_valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> $stable(char_code) && $stable(last_char))
        else $error("char payload changed while stalled");

    a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (char_code == CHAR_MINUS)
                       || ((char_code >= CHAR_ZERO) && (char_code <= CHAR_ZERO + 8'd9)))
        else $error("char_code is neither sign nor digit");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && (char_code == CHAR_MINUS) |-> !last_char)
        else $error("sign flagged as final character");

    a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_stall && (char_code == CHAR_MINUS)
        |=> !(char_valid && ((char_code == CHAR_MINUS) || (char_code == CHAR_ZERO))))
        else $error("sign followed by sign or leading zero");

endmodule

bind signed_int_to_decimal_chars s2d_checker u_s2d_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .last_char  (last_char)
);
